>>> rtl/tspc_pkg.sv
// ----------------------------------------------------------------------------
// tspc_pkg
// Shared types and constants for the per-source-address TCP packet counter.
// ----------------------------------------------------------------------------
package tspc_pkg;

  // frame classification constants
  localparam logic [15:0] EthHeaderBytes    = 16'd14;
  localparam logic [15:0] MinIpv4FrameBytes = 16'd34;
  localparam logic [15:0] EtherTypeIpv4     = 16'h0800;
  localparam logic [7:0]  ProtoTcp          = 8'd6;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] packets;
    logic [63:0] bytes;
  } entry_t;

  // one result word
  typedef struct packed {
    logic        verdict;
    logic        counted;
    logic        table_full;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic clr_idx;    // restart scan at entry 0
    logic inc_idx;    // step scan to next entry
    logic rd;         // read entry at scan index
    logic insert;     // write new entry at scan index
    logic update;     // write incremented entry at scan index
    logic set_plain;  // result for frames that are not counted
    logic set_full;   // result for a failed insert
    logic out_load;   // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tcp;
    logic at_end;
    logic hit;
    logic full;
    logic out_free;
  } status_t;

endpackage

>>> rtl/tspc_if.sv
// ----------------------------------------------------------------------------
// tspc_if
// Valid/ready channels for frame summary words and counter result words.
// ----------------------------------------------------------------------------
interface tspc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;

  modport source (output valid, frame_length, ether_type, ip_protocol, source_address,
                  input ready);
  modport sink (input valid, frame_length, ether_type, ip_protocol, source_address,
                output ready);
endinterface

interface tspc_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic        counted;
  logic        table_full;
  logic [63:0] packet_total;
  logic [63:0] byte_total;

  modport source (output valid, verdict, counted, table_full, packet_total, byte_total,
                  input ready);
  modport sink (input valid, verdict, counted, table_full, packet_total, byte_total,
                output ready);
endinterface

>>> rtl/tspc_ram.sv
// ----------------------------------------------------------------------------
// tspc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tspc_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tspc_ctrl.sv
// ----------------------------------------------------------------------------
// tspc_ctrl
// Sequencer: classify, scan the filled entries, update or insert, deliver.
// ----------------------------------------------------------------------------
module tspc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tspc_pkg::status_t status_i,
  output tspc_pkg::cmd_t    cmd_o
);
  import tspc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.clr_idx = 1'b1;
        if (!status_i.is_tcp) begin
          cmd_o.set_plain = 1'b1;
          state_d         = S_DONE;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status_i.at_end) begin
          // miss: insert at the fill point or report full
          if (status_i.full) begin
            cmd_o.set_full = 1'b1;
          end else begin
            cmd_o.insert = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.hit) begin
          cmd_o.update = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = S_PROBE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tspc_dp.sv
// ----------------------------------------------------------------------------
// tspc_dp
// Datapath: input capture, classification, scan index, fill count, entry RAM,
// counter adders, result and output registers.
// ----------------------------------------------------------------------------
module tspc_dp #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       frame_length_i,
  input  logic [15:0]       ether_type_i,
  input  logic [7:0]        ip_protocol_i,
  input  logic [31:0]       source_address_i,
  input  tspc_pkg::cmd_t    cmd_i,
  output tspc_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tspc_pkg::result_t out_word_o
);
  import tspc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [15:0]   len_q, etype_q;
  logic [7:0]    proto_q;
  logic [31:0]   key_q;
  logic [CW-1:0] idx_q, occ_q;
  result_t       res_q, out_q;
  result_t       res_d;
  logic          out_v_q;

  logic   eth_ok, drop, full;
  entry_t rdata, wdata;
  logic   we;
  logic [63:0] pkt_sum, byte_sum;

  // classification of the captured word
  assign eth_ok = (len_q >= EthHeaderBytes) && (etype_q == EtherTypeIpv4);
  assign drop   = eth_ok && (len_q < MinIpv4FrameBytes);
  assign full   = (occ_q == CW'(TABLE_ENTRIES));

  assign status_o.is_tcp   = eth_ok && !drop && (proto_q == ProtoTcp);
  assign status_o.at_end   = (idx_q == occ_q);
  assign status_o.hit      = (rdata.key == key_q);
  assign status_o.full     = full;
  assign status_o.out_free = !out_v_q || out_ready_i;

  // counter update from the entry just read
  assign pkt_sum  = rdata.packets + 64'd1;
  assign byte_sum = rdata.bytes + {48'd0, len_q};

  always_comb begin
    we    = cmd_i.insert || cmd_i.update;
    wdata.key = key_q;
    if (cmd_i.update) begin
      wdata.packets = pkt_sum;
      wdata.bytes   = byte_sum;
    end else begin
      wdata.packets = 64'd1;
      wdata.bytes   = {48'd0, len_q};
    end
  end

  // next result payload
  always_comb begin
    res_d = '0;
    if (cmd_i.set_plain) begin
      res_d.verdict = drop;
    end else if (cmd_i.set_full) begin
      res_d.table_full = 1'b1;
    end else begin
      res_d.counted      = 1'b1;
      res_d.packet_total = wdata.packets;
      res_d.byte_total   = wdata.bytes;
    end
  end

  // entry table; entries 0 .. occ-1 are the filled ones
  tspc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // input capture and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q   <= frame_length_i;
      etype_q <= ether_type_i;
      proto_q <= ip_protocol_i;
      key_q   <= source_address_i;
    end
    if (cmd_i.set_plain || cmd_i.set_full || we) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // scan index, fill count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      occ_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.insert) begin
        occ_q <= occ_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_insert_at_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (!full && idx_q == occ_q))
    else $error("insert away from fill point or into full table");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= occ_q)
    else $error("scan index past filled entries");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> occ_q == $past(occ_q) + CW'(1))
    else $error("fill count did not advance on insert");

endmodule

>>> rtl/tcp_source_ip_packet_counter_core.sv
// ----------------------------------------------------------------------------
// tcp_source_ip_packet_counter_core
// Counts TCP packets and bytes per IPv4 source address in an exact-match table.
//
//   channel  dir  word contents
//   in_i     in   frame_length, ether_type, ip_protocol, source_address
//   out_o    out  verdict, counted, table_full, packet_total, byte_total
//
// Uncounted frames skip the scan. A TCP word scans the filled entries in
// order, reading one entry at a time from the single RAM read port and
// comparing keys; a hit updates that entry, a miss inserts at the fill point
// or reports a full table. Input is ready again in the cycle after the result
// is loaded into the output register; no new word is taken before that. Reset
// empties the table at once by zeroing the fill count; no clearing pass. A
// stalled output holds the block in its final state.
// ----------------------------------------------------------------------------
module tcp_source_ip_packet_counter_core #(
  parameter int TABLE_ENTRIES = 1024
) (
  input logic         clk_i,
  input logic         rst_ni,
  tspc_in_if.sink     in_i,
  tspc_out_if.source  out_o
);
  import tspc_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t out_word;
  logic    in_ready;

  tspc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tspc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_length_i   (in_i.frame_length),
    .ether_type_i     (in_i.ether_type),
    .ip_protocol_i    (in_i.ip_protocol),
    .source_address_i (in_i.source_address),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_word_o       (out_word)
  );

  assign in_i.ready         = in_ready;
  assign out_o.verdict      = out_word.verdict;
  assign out_o.counted      = out_word.counted;
  assign out_o.table_full   = out_word.table_full;
  assign out_o.packet_total = out_word.packet_total;
  assign out_o.byte_total   = out_word.byte_total;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the per-source-address TCP packet counter against a predictor of
// its own. Frame words are sent in random bursts while the result side stalls
// on its own pattern; every result word is compared field by field with the
// oldest expected word. The counter table is driven to full and beyond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tspc_pkg::*;

  localparam int Entries   = 1024;
  localparam int CycleCap  = 12000000;
  localparam int HoldCycles = 300;

  // one frame summary word
  typedef struct {
    logic [15:0] len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] addr;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tspc_in_if  in_ch ();
  tspc_out_if out_ch ();

  tcp_source_ip_packet_counter_core #(.TABLE_ENTRIES(Entries)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor copy of the flow table
  logic [31:0] flow_key   [Entries];
  logic [63:0] flow_pkts  [Entries];
  logic [63:0] flow_bytes [Entries];
  int          flow_count;

  result_t     expected_results [$];
  logic [31:0] key_pool [$];
  int          mismatches;
  int          cycles;
  int          burst_left;
  bit          holdoff_req;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int find_flow(logic [31:0] addr);
    for (int i = 0; i < flow_count; i++)
      if (flow_key[i] == addr) return i;
    return -1;
  endfunction

  // expected result of one frame; updates the predictor table
  function automatic result_t count_frame(frame_t f);
    result_t r;
    int      slot;
    r = '0;
    if (f.len < EthHeaderBytes || f.etype != EtherTypeIpv4) return r;
    if (f.len < MinIpv4FrameBytes) begin
      r.verdict = 1'b1;
      return r;
    end
    if (f.proto != ProtoTcp) return r;
    slot = find_flow(f.addr);
    if (slot >= 0) begin
      flow_pkts[slot]  = flow_pkts[slot] + 64'd1;
      flow_bytes[slot] = flow_bytes[slot] + {48'd0, f.len};
    end else if (flow_count == Entries) begin
      r.table_full = 1'b1;
      return r;
    end else begin
      slot = flow_count;
      flow_key[slot]   = f.addr;
      flow_pkts[slot]  = 64'd1;
      flow_bytes[slot] = {48'd0, f.len};
      flow_count++;
    end
    r.counted      = 1'b1;
    r.packet_total = flow_pkts[slot];
    r.byte_total   = flow_bytes[slot];
    return r;
  endfunction

  // offer one word, in bursts with random gaps
  task automatic send_frame(frame_t f);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.frame_length   <= f.len;
    in_ch.ether_type     <= f.etype;
    in_ch.ip_protocol    <= f.proto;
    in_ch.source_address <= f.addr;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_results.push_back(count_frame(f));
  endtask

  task automatic send_tcp(logic [15:0] len, logic [31:0] addr);
    frame_t f;
    f = '{len, EtherTypeIpv4, ProtoTcp, addr};
    send_frame(f);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    pick    = $urandom_range(0, 99);
    f.len   = 16'($urandom_range(MinIpv4FrameBytes, 16'hffff));
    f.etype = EtherTypeIpv4;
    f.proto = ProtoTcp;
    f.addr  = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick < 8) f.addr = $urandom();
    else if (pick < 14) f.len = 16'($urandom_range(0, MinIpv4FrameBytes - 1));
    else if (pick < 20) f.etype = 16'($urandom());
    else if (pick < 26) f.proto = 8'($urandom());
    else if (pick < 32) f = '{16'($urandom()), 16'($urandom()), 8'($urandom()), $urandom()};
    return f;
  endfunction

  // result check
  always @(posedge clk_i) begin
    result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.verdict !== want.verdict || out_ch.counted !== want.counted ||
            out_ch.table_full !== want.table_full ||
            out_ch.packet_total !== want.packet_total ||
            out_ch.byte_total !== want.byte_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v%0b c%0b f%0b p%0h b%0h, got v%0b c%0b f%0b p%0h b%0h",
                     want.verdict, want.counted, want.table_full, want.packet_total,
                     want.byte_total, out_ch.verdict, out_ch.counted, out_ch.table_full,
                     out_ch.packet_total, out_ch.byte_total);
        end
      end
    end
  end

  // result side: stall patterns, plus long hold-off on request
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk_i);
        if (holdoff_req) begin
          out_ch.ready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          holdoff_req = 1'b0;
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // directed extremes and special cases
  task automatic test_special_frames();
    frame_t f;
    f = '{16'd0, EtherTypeIpv4, ProtoTcp, 32'h0};        send_frame(f);
    f = '{16'd13, EtherTypeIpv4, ProtoTcp, 32'h0};       send_frame(f);
    f = '{16'd14, EtherTypeIpv4, ProtoTcp, 32'h0};       send_frame(f);
    f = '{16'd33, EtherTypeIpv4, ProtoTcp, 32'h0};       send_frame(f);
    f = '{16'd100, 16'h0008, ProtoTcp, 32'h1};           send_frame(f);
    f = '{16'd100, 16'hffff, ProtoTcp, 32'h1};           send_frame(f);
    f = '{16'hffff, 16'h0000, 8'hff, 32'hffffffff};      send_frame(f);
    f = '{16'd34, EtherTypeIpv4, 8'd0, 32'h2};           send_frame(f);
    f = '{16'd34, EtherTypeIpv4, 8'hff, 32'h2};          send_frame(f);
    f = '{16'd34, EtherTypeIpv4, 8'd17, 32'h2};          send_frame(f);
    send_tcp(16'd34, 32'h0);
    send_tcp(16'hffff, 32'hffffffff);
    send_tcp(16'hffff, 32'hffffffff);
    send_tcp(16'd34, 32'h0);
    send_tcp(16'd1500, 32'h0a000001);
    send_tcp(16'hffff, 32'hffffffff);
    send_tcp(16'd60, 32'h0a000001);
  endtask

  // random traffic over a small address pool, with one long output stall
  task automatic test_random_traffic();
    for (int i = 0; i < 40; i++) key_pool.push_back($urandom());
    key_pool.push_back(32'h0);
    key_pool.push_back(32'hffffffff);
    for (int i = 0; i < 420; i++) begin
      if (i == 150) holdoff_req = 1'b1;
      send_frame(random_frame());
    end
  endtask

  // fill the table with fresh addresses, then run into the full case
  task automatic test_table_fill();
    logic [31:0] addr;
    while (flow_count < Entries) begin
      do addr = $urandom(); while (find_flow(addr) >= 0);
      send_tcp(16'($urandom_range(MinIpv4FrameBytes, 16'hffff)), addr);
    end
    repeat (3) begin
      do addr = $urandom(); while (find_flow(addr) >= 0);
      send_tcp(16'($urandom_range(MinIpv4FrameBytes, 16'hffff)), addr);
    end
  endtask

  // mixed traffic on a full table: hits, refused inserts, noise
  task automatic test_full_table();
    for (int i = 0; i < 220; i++) send_frame(random_frame());
  endtask

  initial begin
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    holdoff_req = 1'b0;
    flow_count = 0;
    in_ch.valid = 1'b0;
    in_ch.frame_length = '0;
    in_ch.ether_type = '0;
    in_ch.ip_protocol = '0;
    in_ch.source_address = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_special_frames();
    test_random_traffic();
    test_table_fill();
    test_full_table();

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> tcp_source_ip_packet_counter_core.f
rtl/tspc_pkg.sv
rtl/tspc_if.sv
rtl/tspc_ram.sv
rtl/tspc_ctrl.sv
rtl/tspc_dp.sv
rtl/tcp_source_ip_packet_counter_core.sv
dv/testbench.sv
